// ----- src/sfm_pkg.sv -----
// Shared types, constants and helpers for the span fill framebuffer.
package sfm_pkg;

    localparam int SCREEN_BITS_DEF = 1024;

    localparam int MODE_W = 1;
    localparam int COORD_W = 10;
    localparam int INDEX_W = 7;
    localparam int LINE_W = 11;
    localparam int PROD_W = COORD_W + LINE_W;
    localparam int POS_W = PROD_W + 1;
    localparam int BYTE_W = 8;
    localparam int STATUS_W = 2;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RST = LINE_W'(64);
    localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DRAWN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OFF = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] row;
        logic [INDEX_W-1:0] byte_index;
    } sfm_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [STATUS_W-1:0] status;
    } sfm_out_t;

    typedef enum logic [1:0] {
        ADDR_CUR,
        ADDR_IDX,
        ADDR_B0,
        ADDR_B1
    } sfm_addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_HEAD,
        WD_FILL,
        WD_TAIL
    } sfm_wd_sel_t;

    typedef struct packed {
        logic ld_item;
        logic ld_prod;
        logic ld_span;
        logic ld_read;
        logic rd_en;
        logic wr_en;
        sfm_addr_sel_t addr_sel;
        sfm_wd_sel_t wd_sel;
        logic cur_inc;
        logic cur_load;
        logic out_load;
    } sfm_cmd_t;

    typedef struct packed {
        logic mode;
        logic span_ok;
        logic single;
        logic cur_at_b1;
        logic cur_at_last;
    } sfm_sts_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ----- src/span_fill_mono_framebuffer.sv -----
// Top level of the 1-bit-per-pixel span fill framebuffer.
// Each req beat either draws a horizontal span (mode 0) or reads one stored
// byte (mode 1) and yields exactly one rsp beat. After reset the framebuffer
// is cleared one byte per cycle over all (SCREEN_BITS + 7) / 8 bytes (128 by
// default), with req_ready low; cfg writes are taken at any time. Items are
// handled one at a time, all framebuffer traffic going through one RAM port
// at one byte per cycle: a read fetches one byte; an accepted draw reads
// and rewrites byte b0 and, if the span ends in a later byte b1, fills the
// bytes between with 0xFF and rewrites b1. A finished result sits in the rsp
// register and the next req beat is taken while it waits. cfg_data sets the
// line width in pixels (reset 64) and may only change while the block is idle.
module span_fill_mono_framebuffer
    import sfm_pkg::*;
#(
    parameter int SCREEN_BITS = SCREEN_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  sfm_in_t           req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sfm_out_t          rsp,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LINE_W-1:0] cfg_data
);

    localparam int STORE_BYTES = (SCREEN_BITS + 7) / 8;
    localparam int ADDR_W = addr_bits(STORE_BYTES);

    sfm_cmd_t          cmd;
    sfm_sts_t          sts;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    assign cfg_ready = 1'b1;

    sfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    sfm_datapath #(
        .SCREEN_BITS (SCREEN_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_rdata (ram_rdata)
    );

    sfm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

endmodule

// ----- src/sfm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sfm_ram
    import sfm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = addr_bits(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/sfm_datapath.sv -----
// Datapath: item registers, span arithmetic, byte masks and framebuffer access.
module sfm_datapath
    import sfm_pkg::*;
#(
    parameter int SCREEN_BITS = SCREEN_BITS_DEF,
    localparam int STORE_BYTES = (SCREEN_BITS + 7) / 8,
    localparam int ADDR_W = addr_bits(STORE_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sfm_cmd_t          cmd,
    output sfm_sts_t          sts,
    input  sfm_in_t           req,
    input  logic              cfg_we,
    input  logic [LINE_W-1:0] cfg_data,
    output sfm_out_t          rsp,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output logic [BYTE_W-1:0] ram_wdata,
    output logic              ram_re,
    input  logic [BYTE_W-1:0] ram_rdata
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    sfm_in_t             item_reg;
    logic [LINE_W-1:0]   width_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   b0_reg, b0_next;
    logic [ADDR_W-1:0]   b1_reg, b1_next;
    logic [BYTE_W-1:0]   head_reg, head_next;
    logic [BYTE_W-1:0]   tail_reg, tail_next;
    logic [ADDR_W-1:0]   cursor_reg;
    logic [STATUS_W-1:0] code_reg, code_next;
    logic [BYTE_W-1:0]   byte_reg;
    sfm_out_t            out_reg;

    logic [POS_W-1:0]          first_bit, last_bit, row_end;
    logic                      off_screen, reversed;
    logic [ADDR_W+INDEX_W-1:0] idx_wide;
    logic                      idx_ok;

    // Row bound: row < SCREEN_BITS / w  <=>  row * w + w <= SCREEN_BITS
    always_comb
    begin
        first_bit = POS_W'(prod_reg) + POS_W'(item_reg.x_start);
        last_bit = POS_W'(prod_reg) + POS_W'(item_reg.x_end);
        row_end = POS_W'(prod_reg) + POS_W'(width_reg);
        off_screen = (width_reg == '0)
            || ({1'b0, item_reg.x_start} >= width_reg)
            || ({1'b0, item_reg.x_end} >= width_reg)
            || (row_end > POS_W'(SCREEN_BITS));
        // columns below w and in order cannot give a span longer than w
        reversed = item_reg.x_end < item_reg.x_start;
        if (off_screen)
        begin
            code_next = ST_OFF;
        end
        else if (reversed)
        begin
            code_next = ST_REJECT;
        end
        else
        begin
            code_next = ST_DRAWN;
        end
        b0_next = ADDR_W'(first_bit >> 3);
        b1_next = ADDR_W'(last_bit >> 3);
        head_next = BYTE_ONES >> first_bit[2:0];
        tail_next = BYTE_ONES << (3'd7 - last_bit[2:0]);
    end

    assign idx_wide = {{ADDR_W{1'b0}}, item_reg.byte_index};
    assign idx_ok = idx_wide < (ADDR_W + INDEX_W)'(STORE_BYTES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= LINE_WIDTH_RST;
            cursor_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                width_reg <= cfg_data;
            end
            if (cmd.cur_load)
            begin
                cursor_reg <= b0_reg + ADDR_W'(1);
            end
            else if (cmd.cur_inc)
            begin
                cursor_reg <= cursor_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            item_reg <= req;
        end
        if (cmd.ld_prod)
        begin
            prod_reg <= {{LINE_W{1'b0}}, item_reg.row} * {{COORD_W{1'b0}}, width_reg};
        end
        if (cmd.ld_span)
        begin
            b0_reg <= b0_next;
            b1_reg <= b1_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            code_reg <= code_next;
            byte_reg <= '0;
        end
        if (cmd.ld_read)
        begin
            code_reg <= ST_READ;
            byte_reg <= idx_ok ? ram_rdata : '0;
        end
        if (cmd.out_load)
        begin
            out_reg.read_data <= byte_reg;
            out_reg.status <= code_reg;
        end
    end

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_CUR: ram_addr = cursor_reg;
            ADDR_IDX: ram_addr = idx_wide[ADDR_W-1:0];
            ADDR_B0:  ram_addr = b0_reg;
            ADDR_B1:  ram_addr = b1_reg;
            default:  ram_addr = cursor_reg;
        endcase
        case (cmd.wd_sel)
            WD_ZERO: ram_wdata = '0;
            WD_HEAD: ram_wdata = ram_rdata | (sts.single ? (head_reg & tail_reg) : head_reg);
            WD_FILL: ram_wdata = BYTE_ONES;
            WD_TAIL: ram_wdata = ram_rdata | tail_reg;
            default: ram_wdata = '0;
        endcase
    end

    assign ram_we = cmd.wr_en;
    assign ram_re = cmd.rd_en;
    assign rsp = out_reg;

    assign sts.mode = item_reg.mode;
    assign sts.span_ok = !off_screen && !reversed;
    assign sts.single = b0_reg == b1_reg;
    assign sts.cur_at_b1 = cursor_reg == b1_reg;
    assign sts.cur_at_last = cursor_reg == LAST_ADDR;

endmodule

// ----- src/sfm_ctrl.sv -----
// Controller: sequences clearing, reads and span fills, owns both handshakes.
module sfm_ctrl
    import sfm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sfm_cmd_t cmd,
    input  sfm_sts_t sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_RDWAIT,
        S_CHECK,
        S_HEAD,
        S_HEADWR,
        S_FILL,
        S_TAILWR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd = '0;
        cmd.addr_sel = ADDR_CUR;
        cmd.wd_sel = WD_ZERO;
        req_ready = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.wr_en = 1'b1;
                cmd.cur_inc = 1'b1;
                if (sts.cur_at_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.ld_prod = 1'b1;
                if (sts.mode == MODE_READ)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr_sel = ADDR_IDX;
                    state_next = S_RDWAIT;
                end
                else
                begin
                    state_next = S_CHECK;
                end
            end
            S_RDWAIT:
            begin
                cmd.ld_read = 1'b1;
                state_next = S_FINISH;
            end
            S_CHECK:
            begin
                cmd.ld_span = 1'b1;
                state_next = sts.span_ok ? S_HEAD : S_FINISH;
            end
            S_HEAD:
            begin
                cmd.rd_en = 1'b1;
                cmd.addr_sel = ADDR_B0;
                state_next = S_HEADWR;
            end
            S_HEADWR:
            begin
                cmd.wr_en = 1'b1;
                cmd.addr_sel = ADDR_B0;
                cmd.wd_sel = WD_HEAD;
                cmd.cur_load = 1'b1;
                state_next = sts.single ? S_FINISH : S_FILL;
            end
            S_FILL:
            begin
                // inner bytes go straight to 0xFF; the last one needs its old value
                if (sts.cur_at_b1)
                begin
                    cmd.rd_en = 1'b1;
                    cmd.addr_sel = ADDR_B1;
                    state_next = S_TAILWR;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    cmd.wd_sel = WD_FILL;
                    cmd.cur_inc = 1'b1;
                end
            end
            S_TAILWR:
            begin
                cmd.wr_en = 1'b1;
                cmd.addr_sel = ADDR_B1;
                cmd.wd_sel = WD_TAIL;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- src/sfm_checker.sv -----
// Port-level assertions for the span fill framebuffer, bound to the top level.
module sfm_checker
    import sfm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input sfm_in_t           req,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input sfm_out_t          rsp,
    input logic              cfg_valid,
    input logic              cfg_ready,
    input logic [LINE_W-1:0] cfg_data
);

    // a stalled rsp beat holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp beat changed while stalled");

    // only reads carry data
    a_draw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != ST_READ |-> rsp.read_data == '0)
        else $error("draw result with nonzero read_data");

    // one item at a time: busy right after a req beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req taken while an item is in work");

    // a new result appears only as the block finishes an item
    a_rsp_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("rsp beat raised while idle");

endmodule

bind span_fill_mono_framebuffer sfm_checker u_sfm_checker (.*);
